// ===== sv/itbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itbd_pkg: shared types and constants of the radix converter
// Field widths, the base limits, the digit alphabet and the job word that
// travels from the front end to the conversion engine.
// ----------------------------------------------------------------------------
package itbd_pkg;

	localparam int VALUE_W = 63;
	localparam int BASE_W  = 5;
	localparam int DIGIT_W = 4;
	localparam int CHAR_W  = 7;
	localparam int STEP_W  = 6;

	localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
	localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;
	localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;

	// One division step per bit of the dividend.
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_W - 1);

	localparam logic [CHAR_W-1:0] ALPHABET [16] = '{
		7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
		7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
	};

	typedef struct packed {
		logic                is_zero;
		logic [BASE_W-1:0]   base;
		logic [VALUE_W-1:0]  value;
	} job_t;

	function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
		logic [BASE_W-1:0] r;
		r = b;
		if (b < BASE_MIN) begin
			r = BASE_MIN;
		end else if (b > BASE_MAX) begin
			r = BASE_MAX;
		end
		return r;
	endfunction

endpackage

// ===== sv/itbd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itbd_in_if: input word channel
// Valid/ready channel that carries the integer to convert.
// ----------------------------------------------------------------------------
interface itbd_in_if;
	logic        valid;
	logic        ready;
	logic [62:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

// ===== sv/itbd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itbd_out_if: output digit channel
// Valid/ready channel that carries one digit, its character and a last flag.
// ----------------------------------------------------------------------------
interface itbd_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] digit_value;
	logic [6:0] digit_char;
	logic       last_digit;

	modport source (output valid, output digit_value, output digit_char,
		output last_digit, input ready);
	modport sink   (input valid, input digit_value, input digit_char,
		input last_digit, output ready);
endinterface

// ===== sv/itbd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itbd_ram: generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module itbd_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/itbd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itbd_front: input front end
// Holds the base register, accepts words, tags them with the clamped base
// and a zero flag, and queues them in a two-entry FIFO for the engine.
// ----------------------------------------------------------------------------
module itbd_front import itbd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [BASE_W-1:0]    cfg_wdata,
	itbd_in_if.sink              data_in,
	output logic                 job_valid,
	output job_t                 job,
	input  logic                 job_pop
);

	logic [BASE_W-1:0] base_q;
	job_t              fifo_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              push;
	job_t              new_job;

	assign data_in.ready = (count_q != 2'd2);
	assign push          = data_in.valid && data_in.ready;
	assign job_valid     = (count_q != 2'd0);
	assign job           = fifo_q[rd_ptr_q];

	always_comb begin
		new_job.value   = data_in.value;
		new_job.base    = clamp_base(base_q);
		new_job.is_zero = (data_in.value == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= BASE_RESET;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (job_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, job_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_job;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2) else $error("front FIFO overfilled");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> count_q != 2'd0) else $error("pop from empty FIFO");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
		else $error("FIFO pointers disagree with occupancy");

endmodule

// ===== sv/itbd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itbd_back: conversion engine
// Bit-serial restoring division by the base, one quotient bit per cycle,
// digits stored least significant first, then read back in reverse order
// into the output register.
// ----------------------------------------------------------------------------
module itbd_back import itbd_pkg::*; #(
	parameter int MAX_DIGITS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         job_valid,
	input  job_t         job,
	output logic         job_pop,
	itbd_out_if.source   digits_out
);

	localparam int AW = $clog2(MAX_DIGITS);
	localparam int CW = $clog2(MAX_DIGITS + 1);
	localparam logic [CW-1:0] MaxCount = CW'(MAX_DIGITS);

	typedef enum logic [1:0] {S_IDLE, S_DIV, S_RD, S_LD} state_t;

	state_t             state_q;
	logic [VALUE_W-1:0] quo_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [BASE_W-1:0]  base_q;
	logic [STEP_W-1:0]  step_q;
	logic [CW-1:0]      cnt_q;
	logic [AW-1:0]      rd_ptr_q;
	logic               out_valid_q;
	logic [DIGIT_W-1:0] out_digit_q;
	logic               out_last_q;

	logic [BASE_W-1:0]  rem_sh;
	logic               q_bit;
	logic [BASE_W-1:0]  rem_new;
	logic [VALUE_W-1:0] quo_new;
	logic [CW-1:0]      cnt_inc;
	logic               out_free;
	logic               out_load;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [DIGIT_W-1:0] ram_wdata;
	logic [DIGIT_W-1:0] ram_rdata;

	// One restoring division step: the remainder stays below the base.
	assign rem_sh  = {rem_q, quo_q[VALUE_W-1]};
	assign q_bit   = (rem_sh >= base_q);
	assign rem_new = q_bit ? (rem_sh - base_q) : rem_sh;
	assign quo_new = {quo_q[VALUE_W-2:0], q_bit};
	assign cnt_inc = cnt_q + CW'(1);

	assign out_free = !out_valid_q || digits_out.ready;
	assign out_load = (state_q == S_LD) && out_free;
	assign job_pop  = (state_q == S_IDLE) && job_valid;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q[AW-1:0];
		ram_wdata = rem_new[DIGIT_W-1:0];
		if (state_q == S_IDLE) begin
			ram_we    = job_valid && job.is_zero;
			ram_waddr = '0;
			ram_wdata = '0;
		end else if (state_q == S_DIV) begin
			ram_we = (step_q == '0);
		end
	end

	itbd_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (MAX_DIGITS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (state_q == S_RD),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			quo_q       <= '0;
			rem_q       <= '0;
			base_q      <= BASE_RESET;
			step_q      <= '0;
			cnt_q       <= '0;
			rd_ptr_q    <= '0;
			out_valid_q <= 1'b0;
			out_digit_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && digits_out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						base_q <= job.base;
						quo_q  <= job.value;
						rem_q  <= '0;
						step_q <= LAST_STEP;
						if (job.is_zero) begin
							cnt_q    <= CW'(1);
							rd_ptr_q <= '0;
							state_q  <= S_RD;
						end else begin
							cnt_q   <= '0;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					quo_q <= quo_new;
					if (step_q == '0) begin
						// Digit complete: it was written to the store this cycle.
						cnt_q  <= cnt_inc;
						rem_q  <= '0;
						step_q <= LAST_STEP;
						if (quo_new == '0 || cnt_inc == MaxCount) begin
							rd_ptr_q <= cnt_q[AW-1:0];
							state_q  <= S_RD;
						end
					end else begin
						rem_q  <= rem_new[DIGIT_W-1:0];
						step_q <= step_q - STEP_W'(1);
					end
				end
				S_RD: begin
					state_q <= S_LD;
				end
				S_LD: begin
					if (out_free) begin
						out_digit_q <= ram_rdata;
						out_last_q  <= (rd_ptr_q == '0);
						if (rd_ptr_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							rd_ptr_q <= rd_ptr_q - AW'(1);
							state_q  <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign digits_out.valid       = out_valid_q;
	assign digits_out.digit_value = out_digit_q;
	assign digits_out.digit_char  = ALPHABET[out_digit_q];
	assign digits_out.last_digit  = out_last_q;

	a_rem_below_base: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < base_q)
		else $error("division remainder not below base");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MaxCount) else $error("digit count beyond store depth");

	a_read_has_digit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> cnt_q != '0)
		else $error("readback started with no stored digit");

	a_base_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> (base_q >= BASE_MIN && base_q <= BASE_MAX))
		else $error("engine running with unclamped base");

endmodule

// ===== sv/integer_to_base_digits.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_base_digits: integer to base 2..16 digit converter
// Converts a 63-bit unsigned integer to its digits in a configurable base
// and streams them out most significant first with their ASCII characters.
// ----------------------------------------------------------------------------
// Usage:
// Words enter on data_in (valid/ready) and digits leave on digits_out, one
// word per digit, the final (least significant) digit flagged by last_digit.
// A zero input yields the single digit '0'. The base register is written
// through cfg_we/cfg_wdata while the block is idle; values below 2 act as 2
// and values above 16 act as 16. Reset sets the base to 10 and empties all
// queues; the digit store needs no clearing since every digit is written
// before it is read.
// The front end queues up to two words, so data_in stays ready until two
// words wait behind the one in the engine. The engine divides by the base
// one quotient bit per cycle, making a full pass over the word for each
// digit; a zero word skips the division. Readback passes through a read
// state and a load state for each digit.
// When digits_out is stalled the output register holds its digit and the
// readback waits; the engine picks up the next word once the last digit of
// the current one sits in the output register.
// ----------------------------------------------------------------------------
module integer_to_base_digits import itbd_pkg::*; #(
	parameter int MAX_DIGITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [BASE_W-1:0] cfg_wdata,
	itbd_in_if.sink           data_in,
	itbd_out_if.source        digits_out
);

	// Job queue between the front end and the engine.
	logic job_valid;
	job_t job;
	logic job_pop;

	itbd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.data_in   (data_in),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop)
	);

	// The engine keeps at most MAX_DIGITS least significant digits.
	itbd_back #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job        (job),
		.job_pop    (job_pop),
		.digits_out (digits_out)
	);

endmodule

// ===== verif/tb_integer_to_base_digits.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_base_digits: self-checking bench for the radix converter
// Sends 63-bit words through data_in and checks every digit on digits_out
// against a behavioral conversion. It starts with a table of directed vectors
// and then runs random words in phases, each phase with its own base and
// amount of idling on both channels.
// ----------------------------------------------------------------------------
module tb_integer_to_base_digits import itbd_pkg::*; ();

	// The converter is built with its default digit capacity. A 63-bit word
	// needs at most 63 digits even in base 2, so nothing is ever truncated.
	localparam int MAX_DIGITS = 64;

	// In base 2 a full-width word keeps the output quiet the longest, since
	// every one of its digits is divided out before the first one leaves, and
	// stalls add to that. The limit on quiet cycles allows several times that.
	localparam int QUIET_LIMIT = 20000;

	// After the last expected digit the bench keeps watching for strays. An
	// extra digit would show up within one division pass.
	localparam int TAIL_CYCLES = 300;

	localparam int PHASES          = 8;
	localparam int WORDS_PER_PHASE = 15;
	localparam int TEXT_CHARS      = 20;

	localparam logic [7:0] CHAR_ZERO     = 8'h30;
	localparam logic [7:0] CHAR_LETTER_A = 8'h41;
	localparam logic [7:0] CHAR_NONE     = 8'h00;

	localparam logic [VALUE_W-1:0] VALUE_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

	// One digit as it appears on the output channel.
	typedef struct packed {
		logic [DIGIT_W-1:0] digit_value;
		logic [CHAR_W-1:0]  digit_char;
		logic               last_digit;
	} digit_t;

	// One row of the directed table. When set_base is high the base register
	// is written (with the block idle) before the word is sent. The expected
	// digits are typed as text where they are obvious; an empty text means
	// the behavioral conversion supplies them.
	typedef struct packed {
		logic                      set_base;
		logic [BASE_W-1:0]         base;
		logic [VALUE_W-1:0]        value;
		logic [8*TEXT_CHARS-1:0]   digits_text;
	} vector_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [BASE_W-1:0] cfg_wdata;

	itbd_in_if  data_if ();
	itbd_out_if dig_if ();

	integer_to_base_digits DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.data_in    (data_if),
		.digits_out (dig_if)
	);

	// Digits still owed by the converter, oldest first.
	digit_t pending_digits[$];

	// Mirror of the base register as last written.
	logic [BASE_W-1:0] base_mirror;

	// Idling knobs. The percentages give the chance that a word or a cycle
	// starts a burst of idling; calm switches idling off entirely.
	int gap_pct;
	int stall_pct;
	bit calm;

	int mismatch_count;
	int words_sent;
	int digits_checked;
	int base_writes;
	int quiet_cycles;

	// Directed vectors: reset base, both ends of the word range, a spread of bases
	// from the clamped extremes to the top of the range, and zero in several
	// bases.
	vector_t directed_vectors [24] = '{
		'{1'b0, 5'd10, 63'd0,                     "0"},
		'{1'b0, 5'd10, 63'd1234567890,            "1234567890"},
		'{1'b0, 5'd10, VALUE_MAX,                 "9223372036854775807"},
		'{1'b1, 5'd16, VALUE_MAX,                 "7FFFFFFFFFFFFFFF"},
		'{1'b0, 5'd16, 63'd0,                     "0"},
		'{1'b0, 5'd16, 63'h0123_4567_89AB_CDEF,   "123456789ABCDEF"},
		'{1'b0, 5'd16, 63'h7EDC_BA98_7654_3210,   "7EDCBA9876543210"},
		'{1'b1, 5'd2,  VALUE_MAX,                 ""},
		'{1'b0, 5'd2,  63'd0,                     "0"},
		'{1'b0, 5'd2,  63'd1,                     "1"},
		'{1'b0, 5'd2,  63'h4000_0000_0000_0000,   ""},
		'{1'b1, 5'd0,  63'd6,                     "110"},
		'{1'b1, 5'd1,  63'd7,                     "111"},
		'{1'b1, 5'd17, 63'd255,                   "FF"},
		'{1'b1, 5'd31, 63'hABC,                   "ABC"},
		'{1'b1, 5'd3,  VALUE_MAX,                 ""},
		'{1'b1, 5'd8,  63'o777,                   "777"},
		'{1'b1, 5'd15, 63'd14,                    "E"},
		'{1'b0, 5'd15, 63'd15,                    "10"},
		'{1'b1, 5'd7,  63'h4000_0000_0000_0000,   ""},
		'{1'b1, 5'd11, 63'd10,                    "A"},
		'{1'b1, 5'd12, 63'h5555_5555_5555_5555,   ""},
		'{1'b1, 5'd9,  63'd1000000000,            ""},
		'{1'b1, 5'd10, 63'd1000000000000000000,   "1000000000000000000"}
	};

	initial begin
		clk = 1'b0;
	end

	always begin
		#2 clk = ~clk;
	end

	// Works out the digits of one word in the given raw base and queues them,
	// most significant first. The remainders come out least significant
	// first, so they are collected before being queued in reverse.
	function automatic void predict_digits(input logic [VALUE_W-1:0] word,
			input logic [BASE_W-1:0] raw_base);
		logic [63:0] rest;
		logic [63:0] radix;
		logic [DIGIT_W-1:0] found [MAX_DIGITS];
		int count;
		digit_t d;
		radix = 64'(raw_base);
		if (radix < 64'(BASE_MIN)) begin
			radix = 64'(BASE_MIN);
		end else if (radix > 64'(BASE_MAX)) begin
			radix = 64'(BASE_MAX);
		end
		rest = 64'(word);
		count = 0;
		if (rest == 64'd0) begin
			// Zero still produces one digit.
			found[0] = '0;
			count = 1;
		end else begin
			while (rest != 64'd0 && count < MAX_DIGITS) begin
				found[count] = DIGIT_W'(rest % radix);
				rest = rest / radix;
				count++;
			end
		end
		for (int k = count - 1; k >= 0; k--) begin
			d.digit_value = found[k];
			if (found[k] < 4'd10) begin
				d.digit_char = CHAR_W'(CHAR_ZERO + 8'(found[k]));
			end else begin
				d.digit_char = CHAR_W'(CHAR_LETTER_A + 8'(found[k]) - 8'd10);
			end
			d.last_digit = (k == 0);
			pending_digits.push_back(d);
		end
	endfunction

	// Queues the digits typed as text in a directed row. The text sits
	// right-aligned in its field with empty characters in front.
	function automatic void expect_from_text(input logic [8*TEXT_CHARS-1:0] text);
		logic [7:0] c;
		digit_t d;
		for (int i = TEXT_CHARS - 1; i >= 0; i--) begin
			c = text[i*8 +: 8];
			if (c != CHAR_NONE) begin
				if (c >= CHAR_LETTER_A) begin
					d.digit_value = DIGIT_W'(c - CHAR_LETTER_A + 8'd10);
				end else begin
					d.digit_value = DIGIT_W'(c - CHAR_ZERO);
				end
				d.digit_char = c[CHAR_W-1:0];
				d.last_digit = 1'b0;
				pending_digits.push_back(d);
			end
		end
		pending_digits[pending_digits.size() - 1].last_digit = 1'b1;
	endfunction

	// Random word. Most words are short so that the slow bases stay cheap; a
	// share of full-width words makes every bit of the field toggle, and a
	// few zeros exercise the single-digit case.
	function automatic logic [VALUE_W-1:0] random_value();
		logic [63:0] r;
		int width;
		int pick;
		r = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			return '0;
		end else if (pick < 20) begin
			width = VALUE_W;
		end else if (pick < 40) begin
			width = $urandom_range(21, VALUE_W - 1);
		end else begin
			width = $urandom_range(1, 20);
		end
		return VALUE_W'(r & ((64'd1 << width) - 64'd1));
	endfunction

	// Offers one word and returns at the edge where it is taken. Valid stays
	// high afterwards, so back-to-back words need no extra assignment; an
	// idle gap, when one is drawn, lowers it first.
	task automatic send_word(input logic [VALUE_W-1:0] word);
		int gap;
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 11);
			data_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		data_if.valid <= 1'b1;
		data_if.value <= word;
		do begin
			@(posedge clk);
		end while (!data_if.ready);
		words_sent++;
	endtask

	// Stops sending and waits until every owed digit has come out. Since
	// every word yields at least one digit, the converter is idle then.
	task automatic wait_for_idle();
		data_if.valid <= 1'b0;
		while (pending_digits.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_base(input logic [BASE_W-1:0] raw_base);
		cfg_wdata <= raw_base;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		base_mirror = raw_base;
		base_writes++;
	endtask

	// Receiver. Ready drops in bursts that start at a rate set per phase, and
	// stays high once the bench is calm.
	initial begin : digit_sink
		int stall_left;
		dig_if.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				dig_if.ready <= 1'b0;
			end else if (!calm && stall_left > 0) begin
				dig_if.ready <= 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(0, 10);
				dig_if.ready <= 1'b0;
			end else begin
				dig_if.ready <= 1'b1;
			end
		end
	end

	// Checks each digit taken from the converter against the oldest owed
	// digit.
	always @(posedge clk) begin : digit_check
		digit_t want;
		if (arst_n && dig_if.valid && dig_if.ready) begin
			digits_checked++;
			if (pending_digits.size() == 0) begin
				$error("digit %0d (char %0d, last %0d) arrived with none owed",
					dig_if.digit_value, dig_if.digit_char, dig_if.last_digit);
				mismatch_count++;
			end else begin
				want = pending_digits.pop_front();
				if (dig_if.digit_value !== want.digit_value) begin
					$error("digit_value: expected %0d, actual %0d",
						want.digit_value, dig_if.digit_value);
					mismatch_count++;
				end
				if (dig_if.digit_char !== want.digit_char) begin
					$error("digit_char: expected %0d, actual %0d",
						want.digit_char, dig_if.digit_char);
					mismatch_count++;
				end
				if (dig_if.last_digit !== want.last_digit) begin
					$error("last_digit: expected %0d, actual %0d",
						want.last_digit, dig_if.last_digit);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: any word moving on either channel restarts the count of quiet
	// cycles. A hung converter or a lost digit ends the run here.
	always @(posedge clk) begin
		if (!arst_n || (data_if.valid && data_if.ready) || (dig_if.valid && dig_if.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: %0d quiet cycles with %0d digits still owed",
					quiet_cycles, pending_digits.size());
				$display("FAIL integer_to_base_digits");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [VALUE_W-1:0] word;
		logic [BASE_W-1:0] phase_base;

		// Every input is known from time zero, while reset is held asserted.
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		data_if.valid = 1'b0;
		data_if.value = '0;
		base_mirror = BASE_RESET;
		gap_pct = 30;
		stall_pct = 30;
		calm = 1'b0;
		mismatch_count = 0;
		words_sent = 0;
		digits_checked = 0;
		base_writes = 0;
		quiet_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. The first rows run on the reset base, so they also
		// confirm the register's reset value. A base change always waits for
		// the converter to drain, which also makes the sender hold off until
		// every owed digit is in.
		foreach (directed_vectors[i]) begin
			if (directed_vectors[i].set_base) begin
				wait_for_idle();
				write_base(directed_vectors[i].base);
			end
			send_word(directed_vectors[i].value);
			if (directed_vectors[i].digits_text != '0) begin
				expect_from_text(directed_vectors[i].digits_text);
			end else begin
				predict_digits(directed_vectors[i].value, base_mirror);
			end
		end

		// Random phases. The first two pin the base at its extremes, the rest
		// draw any 5-bit value so that clamping keeps getting exercised. The
		// last phase runs with no idling at all.
		for (int p = 0; p < PHASES; p++) begin
			wait_for_idle();
			if (p == 0) begin
				phase_base = BASE_MIN;
			end else if (p == 1) begin
				phase_base = BASE_MAX;
			end else begin
				phase_base = BASE_W'($urandom_range(0, 31));
			end
			write_base(phase_base);
			calm = (p == PHASES - 1);
			case ($urandom_range(0, 2))
				0: begin
					gap_pct = 0;
				end
				1: begin
					gap_pct = 15;
				end
				default: begin
					gap_pct = 45;
				end
			endcase
			case ($urandom_range(0, 2))
				0: begin
					stall_pct = 0;
				end
				1: begin
					stall_pct = 10;
				end
				default: begin
					stall_pct = 35;
				end
			endcase
			repeat (WORDS_PER_PHASE) begin
				word = random_value();
				send_word(word);
				predict_digits(word, base_mirror);
			end
		end

		wait_for_idle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Converted %0d words into %0d checked digits over %0d base writes,",
			words_sent, digits_checked, base_writes);
		$display("covering bases 2 to 16, clamped raw bases, zero and full-width words.");
		if (mismatch_count == 0) begin
			$display("PASS integer_to_base_digits");
		end else begin
			$display("FAIL integer_to_base_digits");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/itbd_pkg.sv
sv/itbd_in_if.sv
sv/itbd_out_if.sv
sv/itbd_ram.sv
sv/itbd_front.sv
sv/itbd_back.sv
sv/integer_to_base_digits.sv
verif/tb_integer_to_base_digits.sv
